[hdl/rdlc_pkg.sv]
// shared constants and controller/datapath interface types for the
// range distinct letter counter; no dependencies
package rdlc_pkg;

  // string length and alphabet size
  localparam int SIZE    = 1024;
  localparam int LETTERS = 26;

  // field and storage widths
  localparam int ADDR_W = $clog2(SIZE);
  localparam int IDX_W  = ADDR_W + 1;
  localparam int LET_W  = 5;
  localparam int CNT_W  = $clog2(SIZE + 1);
  localparam int ROW_W  = LETTERS * CNT_W;
  localparam int OUT_W  = 5;

  // letter code of an empty slot
  localparam logic [LET_W-1:0] LET_EMPTY = LET_W'(LETTERS);

  // request actions
  localparam logic ACT_SET   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture a new request
    logic clr_wr;     // write reset values at clear pointer
    logic let_rd;     // read letter slot at position
    logic let_cap;    // capture old letter, start update walk
    logic let_wr;     // write new letter at position
    logic upd_rd;     // read tree row at update index
    logic upd_wr;     // write modified row, step update index
    logic q_init_hi;  // clear sums, start walk at right end + 1
    logic q_init_lo;  // start walk at left end
    logic q_rd;       // read tree row at query index - 1
    logic q_acc_hi;   // add row into upper prefix sums
    logic q_acc_lo;   // add row into lower prefix sums
    logic emit;       // count letters and present result
  } rdlc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;   // clear pointer at last row
    logic set_skip;   // set request changes nothing
    logic upd_done;   // update walk left the tree
    logic walk_zero;  // query walk index reached zero
    logic q_empty;    // left end beyond right end
  } rdlc_sts_t;

endpackage

[hdl/rdlc_ram.sv]
// generic single-port RAM with registered read
// no dependencies
module rdlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/rdlc_dp.sv]
// datapath: letter store, per-node count rows, walk indexes and prefix sums
// depends on rdlc_pkg and rdlc_ram
module rdlc_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rdlc_pkg::rdlc_cmd_t         cmd,
  output rdlc_pkg::rdlc_sts_t         sts,
  input  logic [rdlc_pkg::ADDR_W-1:0] in_position,
  input  logic [rdlc_pkg::LET_W-1:0]  in_letter,
  input  logic [rdlc_pkg::ADDR_W-1:0] in_left_end,
  input  logic [rdlc_pkg::ADDR_W-1:0] in_right_end,
  output logic                        out_valid,
  output logic [rdlc_pkg::OUT_W-1:0]  out_distinct_count
);

  import rdlc_pkg::*;

  // request registers
  logic [ADDR_W-1:0] pos_r;
  logic [LET_W-1:0]  let_r;
  logic [ADDR_W-1:0] l_r;
  logic [ADDR_W-1:0] r_r;
  logic [LET_W-1:0]  old_r;

  // walk indexes and clear pointer
  logic [IDX_W-1:0]  j_r;
  logic [IDX_W-1:0]  i_r;
  logic [IDX_W-1:0]  i_dec;
  logic [ADDR_W-1:0] clr_r;

  // prefix sums per letter
  logic [CNT_W-1:0]  sum_hi_r [LETTERS];
  logic [CNT_W-1:0]  sum_lo_r [LETTERS];

  // result registers
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_cnt_r;
  logic [OUT_W-1:0]  cnt_nxt;

  // memory ports
  logic              let_we;
  logic [ADDR_W-1:0] let_addr;
  logic [LET_W-1:0]  let_wdata;
  logic [LET_W-1:0]  let_rdata;
  logic              tree_we;
  logic [ADDR_W-1:0] tree_addr;
  logic [ROW_W-1:0]  tree_wdata;
  logic [ROW_W-1:0]  tree_rdata;
  logic [ROW_W-1:0]  row_mod;

  assign i_dec = i_r - IDX_W'(1);

  // letter store
  assign let_we    = cmd.clr_wr | cmd.let_wr;
  assign let_addr  = cmd.clr_wr ? clr_r : pos_r;
  assign let_wdata = cmd.clr_wr ? LET_EMPTY : let_r;

  rdlc_ram #(
    .WIDTH (LET_W),
    .DEPTH (SIZE)
  ) u_let_ram (
    .clk   (clk),
    .we    (let_we),
    .addr  (let_addr),
    .wdata (let_wdata),
    .rdata (let_rdata)
  );

  // count rows, one row of all letters per tree node
  always_comb begin
    row_mod = tree_rdata;
    for (int c = 0; c < LETTERS; c++) begin
      if (let_r == LET_W'(c)) begin
        row_mod[c*CNT_W +: CNT_W] = tree_rdata[c*CNT_W +: CNT_W] + CNT_W'(1);
      end else if (old_r == LET_W'(c)) begin
        row_mod[c*CNT_W +: CNT_W] = tree_rdata[c*CNT_W +: CNT_W] - CNT_W'(1);
      end
    end
  end

  assign tree_we    = cmd.clr_wr | cmd.upd_wr;
  assign tree_wdata = cmd.clr_wr ? '0 : row_mod;

  always_comb begin
    if (cmd.clr_wr) begin
      tree_addr = clr_r;
    end else if (cmd.q_rd) begin
      tree_addr = i_dec[ADDR_W-1:0];
    end else begin
      tree_addr = j_r[ADDR_W-1:0];
    end
  end

  rdlc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SIZE)
  ) u_tree_ram (
    .clk   (clk),
    .we    (tree_we),
    .addr  (tree_addr),
    .wdata (tree_wdata),
    .rdata (tree_rdata)
  );

  // status toward the controller
  assign sts.clr_last  = (clr_r == ADDR_W'(SIZE - 1));
  assign sts.set_skip  = (let_r >= LET_EMPTY) || (let_rdata == let_r);
  assign sts.upd_done  = (j_r >= IDX_W'(SIZE));
  assign sts.walk_zero = (i_r == '0);
  assign sts.q_empty   = (l_r > r_r);

  // letters whose upper prefix count exceeds the lower one
  always_comb begin
    cnt_nxt = '0;
    for (int c = 0; c < LETTERS; c++) begin
      if (sum_hi_r[c] > sum_lo_r[c]) begin
        cnt_nxt = cnt_nxt + OUT_W'(1);
      end
    end
  end

  // request capture and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r <= in_position;
      let_r <= in_letter;
      l_r   <= in_left_end;
      r_r   <= in_right_end;
    end
    if (cmd.let_cap) begin
      old_r <= let_rdata;
      j_r   <= {1'b0, pos_r};
    end else if (cmd.upd_wr) begin
      j_r <= j_r | (j_r + IDX_W'(1));
    end
    if (cmd.q_init_hi) begin
      i_r <= {1'b0, r_r} + IDX_W'(1);
    end else if (cmd.q_init_lo) begin
      i_r <= {1'b0, l_r};
    end else if (cmd.q_acc_hi || cmd.q_acc_lo) begin
      i_r <= i_r & i_dec;
    end
  end

  // prefix sum lanes
  always_ff @(posedge clk) begin
    for (int c = 0; c < LETTERS; c++) begin
      if (cmd.q_init_hi) begin
        sum_hi_r[c] <= '0;
        sum_lo_r[c] <= '0;
      end else if (cmd.q_acc_hi) begin
        sum_hi_r[c] <= sum_hi_r[c] + tree_rdata[c*CNT_W +: CNT_W];
      end else if (cmd.q_acc_lo) begin
        sum_lo_r[c] <= sum_lo_r[c] + tree_rdata[c*CNT_W +: CNT_W];
      end
    end
  end

  // clear pointer and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_cnt_r <= cnt_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_distinct_count = out_cnt_r;

endmodule

[hdl/rdlc_ctrl.sv]
// controller state machine: clearing pass, set update walk, query walks
// depends on rdlc_pkg
module rdlc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_action,
  output logic                busy,
  input  rdlc_pkg::rdlc_sts_t sts,
  output rdlc_pkg::rdlc_cmd_t cmd
);

  import rdlc_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_CHK,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SET_WR,
    ST_Q_INIT,
    ST_QH_RD,
    ST_QH_ACC,
    ST_QL_RD,
    ST_QL_ACC,
    ST_Q_CNT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (in_action == ACT_SET) ? ST_SET_RD : ST_Q_INIT;
        end
      end
      ST_SET_RD: begin
        cmd.let_rd = 1'b1;
        state_nxt  = ST_SET_CHK;
      end
      ST_SET_CHK: begin
        cmd.let_cap = 1'b1;
        state_nxt   = sts.set_skip ? ST_IDLE : ST_UPD_RD;
      end
      ST_UPD_RD: begin
        if (sts.upd_done) begin
          state_nxt = ST_SET_WR;
        end else begin
          cmd.upd_rd = 1'b1;
          state_nxt  = ST_UPD_WR;
        end
      end
      ST_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = ST_UPD_RD;
      end
      ST_SET_WR: begin
        cmd.let_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_Q_INIT: begin
        cmd.q_init_hi = 1'b1;
        state_nxt     = sts.q_empty ? ST_Q_CNT : ST_QH_RD;
      end
      ST_QH_RD: begin
        if (sts.walk_zero) begin
          cmd.q_init_lo = 1'b1;
          state_nxt     = ST_QL_RD;
        end else begin
          cmd.q_rd  = 1'b1;
          state_nxt = ST_QH_ACC;
        end
      end
      ST_QH_ACC: begin
        cmd.q_acc_hi = 1'b1;
        state_nxt    = ST_QH_RD;
      end
      ST_QL_RD: begin
        if (sts.walk_zero) begin
          state_nxt = ST_Q_CNT;
        end else begin
          cmd.q_rd  = 1'b1;
          state_nxt = ST_QL_ACC;
        end
      end
      ST_QL_ACC: begin
        cmd.q_acc_lo = 1'b1;
        state_nxt    = ST_QL_RD;
      end
      ST_Q_CNT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

[hdl/range_distinct_letter_counter_unit.sv]
// Range distinct letter counter: keeps a 1024-slot string of letters a..z and,
// per tree node, a row of 26 occurrence counts (binary indexed tree).
// A request is taken when start is high and busy is low.
//   in_action = 0: set in_letter at in_position. Same letter, or a letter code
//     of 26 or more, changes nothing. Otherwise the old count is withdrawn
//     and the new one added in one read-modify-write walk over the node
//     rows. No result.
//   in_action = 1: count the distinct letters in in_left_end..in_right_end.
//     Two prefix walks; left beyond right gives 0. The result is on
//     out_distinct_count with out_valid high for one cycle, the first cycle
//     after busy falls.
// One request is handled at a time; each step reads (and writes back) one
// node row through the single row port of the count memory.
// After reset a clearing pass writes every slot empty and every count row
// zero; busy stays high during it.
// The result is a strobe: the receiver must take it in that cycle.
// depends on rdlc_pkg, rdlc_ctrl, rdlc_dp
module range_distinct_letter_counter_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_action,
  input  logic [rdlc_pkg::ADDR_W-1:0] in_position,
  input  logic [rdlc_pkg::LET_W-1:0]  in_letter,
  input  logic [rdlc_pkg::ADDR_W-1:0] in_left_end,
  input  logic [rdlc_pkg::ADDR_W-1:0] in_right_end,
  output logic                        out_valid,
  output logic [rdlc_pkg::OUT_W-1:0]  out_distinct_count
);

  import rdlc_pkg::*;

  rdlc_cmd_t cmd;
  rdlc_sts_t sts;

  // sequencer
  rdlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .busy      (busy),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage and arithmetic
  rdlc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_position        (in_position),
    .in_letter          (in_letter),
    .in_left_end        (in_left_end),
    .in_right_end       (in_right_end),
    .out_valid          (out_valid),
    .out_distinct_count (out_distinct_count)
  );

endmodule

[sim/tb_top.sv]
// self-checking testbench for range_distinct_letter_counter_unit
// drives set and query requests, predicts distinct counts with a fenwick model
// depends on rdlc_pkg and the range_distinct_letter_counter_unit rtl
module tb_top;
  import rdlc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int END_WAIT    = 64;

  // one pending request; a drain entry holds the sender until results are in
  typedef struct packed {
    logic              drain;
    logic              action;
    logic [ADDR_W-1:0] position;
    logic [LET_W-1:0]  letter;
    logic [ADDR_W-1:0] left_end;
    logic [ADDR_W-1:0] right_end;
  } request_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_action = 1'b0;
  logic [ADDR_W-1:0] in_position = '0;
  logic [LET_W-1:0]  in_letter = '0;
  logic [ADDR_W-1:0] in_left_end = '0;
  logic [ADDR_W-1:0] in_right_end = '0;
  logic              out_valid;
  logic [OUT_W-1:0]  out_distinct_count;

  request_t          request_q[$];
  logic [OUT_W-1:0]  pending_counts[$];

  // model state: letter per slot and fenwick node counts per letter
  logic [LET_W-1:0]  slot_letter[SIZE];
  int unsigned       node_count[SIZE*LETTERS];
  // fill-time copy of the string, used to build same-letter writes
  logic [LET_W-1:0]  planned_letter[SIZE];

  logic taken = 1'b0;
  logic drain_wait = 1'b0;
  int   gap_left = 0;
  int   burst_left = 1;
  int   cycle_count = 0;
  int   error_count = 0;

  range_distinct_letter_counter_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_position        (in_position),
    .in_letter          (in_letter),
    .in_left_end        (in_left_end),
    .in_right_end       (in_right_end),
    .out_valid          (out_valid),
    .out_distinct_count (out_distinct_count)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("tb_top: mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // walk the fenwick path of one letter from a slot upward
  task automatic walk_update(input int pos, input int ltr, input bit up);
    int j;
    j = pos;
    while (j < SIZE) begin
      if (up) node_count[j*LETTERS+ltr] += 1;
      else node_count[j*LETTERS+ltr] -= 1;
      j = j | (j + 1);
    end
  endtask

  // write a letter into the model string
  task automatic apply_set(input logic [ADDR_W-1:0] pos, input logic [LET_W-1:0] ltr);
    int old;
    old = slot_letter[pos];
    if (ltr >= LETTERS) return;
    if (old == ltr) return;
    if (old < LETTERS) walk_update(pos, old, 1'b0);
    walk_update(pos, ltr, 1'b1);
    slot_letter[pos] = ltr;
  endtask

  // occurrences of one letter over slots 0..n-1
  function automatic int unsigned prefix_sum(input int n, input int ltr);
    int unsigned s;
    int i;
    s = 0;
    i = n;
    while (i != 0) begin
      s += node_count[(i-1)*LETTERS+ltr];
      i = i & (i - 1);
    end
    return s;
  endfunction

  // number of letters present in left..right
  function automatic logic [OUT_W-1:0] distinct_in_range(input logic [ADDR_W-1:0] lo,
                                                         input logic [ADDR_W-1:0] hi);
    int l;
    int r;
    int n;
    l = lo;
    r = hi;
    n = 0;
    if (r >= SIZE) r = SIZE - 1;
    if (l < SIZE && l <= r) begin
      for (int c = 0; c < LETTERS; c++) begin
        if (prefix_sum(r + 1, c) > prefix_sum(l, c)) n++;
      end
    end
    if (n > 31) n = 31;
    return OUT_W'(n);
  endfunction

  function automatic request_t make_req(input logic act, input int pos, input int ltr,
                                        input int l, input int r);
    request_t q;
    q.drain     = 1'b0;
    q.action    = act;
    q.position  = ADDR_W'(pos);
    q.letter    = LET_W'(ltr);
    q.left_end  = ADDR_W'(l);
    q.right_end = ADDR_W'(r);
    return q;
  endfunction

  // set request with random unused query fields; tracks the planned string
  function automatic request_t set_req(input int pos, input int ltr);
    if (ltr < LETTERS) planned_letter[pos] = LET_W'(ltr);
    return make_req(ACT_SET, pos, ltr, $urandom_range(0, SIZE-1), $urandom_range(0, SIZE-1));
  endfunction

  function automatic request_t query_req(input int l, input int r);
    return make_req(ACT_QUERY, $urandom_range(0, SIZE-1), $urandom_range(0, 31), l, r);
  endfunction

  function automatic request_t drain_req();
    request_t q;
    q = '0;
    q.drain = 1'b1;
    return q;
  endfunction

  // driver: present requests at the falling edge, bursts with random gaps
  always @(negedge clk) begin : drive_requests
    logic keep;
    logic launch;
    request_t nxt;
    keep = start && !taken;
    launch = 1'b0;
    nxt = '0;
    if (rst_n && !keep) begin
      if (drain_wait) begin
        if (pending_counts.size() == 0) drain_wait = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (request_q.size() > 0) begin
        nxt = request_q.pop_front();
        if (nxt.drain) begin
          drain_wait = 1'b1;
        end else begin
          launch = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end
        end
      end
    end
    if (launch) begin
      start        <= 1'b1;
      in_action    <= nxt.action;
      in_position  <= nxt.position;
      in_letter    <= nxt.letter;
      in_left_end  <= nxt.left_end;
      in_right_end <= nxt.right_end;
    end else if (!keep) begin
      start <= 1'b0;
    end
  end

  // monitor: check strobed results, predict each accepted request
  always @(posedge clk) begin : check_results
    logic [OUT_W-1:0] want;
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      taken <= 1'b0;
    end else begin
      if (out_valid === 1'b1) begin
        if (pending_counts.size() == 0) begin
          report_mismatch("result with no query outstanding");
        end else begin
          want = pending_counts.pop_front();
          if (out_distinct_count !== want)
            report_mismatch($sformatf("distinct_count %0d, expected %0d",
                                      out_distinct_count, want));
        end
      end
      if (start && busy === 1'b0) begin
        if (in_action == ACT_SET) apply_set(in_position, in_letter);
        else pending_counts.push_back(distinct_in_range(in_left_end, in_right_end));
      end
      taken <= start && (busy === 1'b0);
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: FAIL");
    $finish;
  end

  // stimulus and end of run
  initial begin : stimulus
    int win_lo;
    int pick;
    int pos;
    int ltr;
    int a;
    int b;
    for (int i = 0; i < SIZE; i++) begin
      slot_letter[i] = LET_EMPTY;
      planned_letter[i] = LET_EMPTY;
    end
    for (int i = 0; i < SIZE*LETTERS; i++) node_count[i] = 0;

    // directed: empty string, field extremes, same letter, ignored letters
    request_q.push_back(query_req(0, SIZE-1));
    request_q.push_back(set_req(0, 0));
    request_q.push_back(set_req(SIZE-1, LETTERS-1));
    request_q.push_back(set_req(512, 13));
    request_q.push_back(set_req(1, 1));
    request_q.push_back(query_req(0, SIZE-1));
    request_q.push_back(set_req(0, 0));
    request_q.push_back(set_req(5, LETTERS));
    request_q.push_back(set_req(5, 31));
    request_q.push_back(query_req(0, 10));
    request_q.push_back(set_req(512, LETTERS-1));
    request_q.push_back(query_req(0, 0));
    request_q.push_back(query_req(SIZE-1, SIZE-1));
    request_q.push_back(query_req(1, SIZE-2));
    request_q.push_back(query_req(512, 512));
    request_q.push_back(query_req(SIZE-1, 0));
    request_q.push_back(query_req(600, 599));
    request_q.push_back(query_req(0, 511));
    request_q.push_back(query_req(513, SIZE-1));
    request_q.push_back(set_req(SIZE-1, 0));
    request_q.push_back(query_req(0, SIZE-1));
    request_q.push_back(drain_req());

    // random: writes mostly within a moving window, queries mostly over random ranges
    win_lo = 0;
    for (int k = 0; k < 800; k++) begin
      if (k % 100 == 0) win_lo = $urandom_range(0, SIZE-64);
      if (k % 200 == 199) request_q.push_back(drain_req());
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        pos = ($urandom_range(0, 2) == 0) ? $urandom_range(0, SIZE-1)
                                          : win_lo + $urandom_range(0, 63);
        if ($urandom_range(0, 9) == 0) ltr = $urandom_range(LETTERS, 31);
        else if ($urandom_range(0, 9) == 0 && planned_letter[pos] != LET_EMPTY)
          ltr = planned_letter[pos];
        else ltr = $urandom_range(0, LETTERS-1);
        request_q.push_back(set_req(pos, ltr));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          a = $urandom_range(0, SIZE-1);
          b = $urandom_range(0, SIZE-1);
          request_q.push_back(query_req((a < b) ? a : b, (a < b) ? b : a));
        end else if (pick < 9) begin
          a = win_lo + $urandom_range(0, 63);
          b = a + $urandom_range(0, 63);
          if (b > SIZE-1) b = SIZE-1;
          request_q.push_back(query_req(a, b));
        end else begin
          request_q.push_back(query_req($urandom_range(0, SIZE-1), $urandom_range(0, SIZE-1)));
        end
      end
    end

    // reset
    rst_n = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // wait for every request to go in and every result to come back
    while (request_q.size() != 0 || start || drain_wait) @(posedge clk);
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (pending_counts.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_counts.size()));

    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/rdlc_pkg.sv
hdl/rdlc_ram.sv
hdl/rdlc_dp.sv
hdl/rdlc_ctrl.sv
hdl/range_distinct_letter_counter_unit.sv
sim/tb_top.sv
